@@ rtl/core/spscq_pkg.sv @@
// shared types and constants for the single-producer single-consumer ring queue
package spscq_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int SIZE_W  = IDX_W + 1;
  localparam int ELEM_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 8;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 64;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_COMMIT  = 3'd1,
    CMD_READ    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e_t;

  // request from the control path to the slot store, one per accepted item
  typedef struct packed {
    logic              en;
    logic              wr;
    logic              rd;
    logic [IDX_W-1:0]  addr;
    logic [ELEM_W-1:0] wdata;
  } store_req_t;

  // counts in the order they are packed into the result tdata, lowest last
  typedef struct packed {
    logic [CNT_W-1:0] avail_read;
    logic [CNT_W-1:0] contig_read;
    logic [CNT_W-1:0] avail_write;
    logic [CNT_W-1:0] contig_write;
  } counts_t;

endpackage

@@ rtl/core/spscq_store.sv @@
// slot store: element memory with per-entry valid bits so unwritten slots read as zero
module spscq_store (
  input  logic                          clk,
  input  logic                          rst,
  input  spscq_pkg::store_req_t         req,
  output logic [spscq_pkg::ELEM_W-1:0]  rd_data
);

  logic [spscq_pkg::ELEM_W-1:0] mem [spscq_pkg::DEPTH];
  logic [spscq_pkg::DEPTH-1:0]  valid;
  logic [spscq_pkg::ELEM_W-1:0] rd_q;
  logic                         rd_keep;

  always_ff @(posedge clk) begin
    if (req.en && req.wr) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.en && req.wr) begin
      valid[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_q <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_keep <= 1'b0;
    end else if (req.en) begin
      rd_keep <= req.rd && valid[req.addr];
    end
  end

  assign rd_data = rd_keep ? rd_q : '0;

endmodule

@@ rtl/core/spsc_ring_queue_core.sv @@
// top level of the ring queue: command decode, head/tail update and result pipeline
//
// Ring queue of up to 256 32-bit slots that always keeps one slot empty.
// Each item carries one command (write slot, commit write, read slot,
// release read, clear) and yields exactly one result with a status, the
// read data and the contiguous and total write/read counts after the
// command. One item is accepted per cycle while the result stages are not
// stalled by m_axis_tready; a result passes the registered read of the slot
// memory and then the output register. Writing num_slots on the config channel
// (only while no item is in flight) resizes the ring and empties it, keeping
// stored elements. Slots never written since reset read as zero; no clearing
// pass is needed after reset.
module spsc_ring_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,       // num_slots
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // data[31:0], offset[39:32], amount[47:40]
  input  logic [2:0]  s_axis_tuser,   // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // read_data[31:0], contig_write[39:32],
                                      // avail_write[47:40], contig_read[55:48],
                                      // avail_read[63:56]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int IW = spscq_pkg::IDX_W;
  localparam int SW = spscq_pkg::SIZE_W;

  logic [SW-1:0] ring_n;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail_next;

  spscq_pkg::cmd_e_t    cmd;
  spscq_pkg::status_e_t status_next;
  spscq_pkg::store_req_t req;
  spscq_pkg::counts_t   cnt_now;
  spscq_pkg::counts_t   cnt_next;

  logic [spscq_pkg::ELEM_W-1:0] in_data;
  logic [7:0]    in_offset;
  logic [7:0]    in_amount;
  logic          in_fire;
  logic          cfg_fire;
  logic [SW-1:0] wr_addr;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] cfg_size;

  logic                  s1_valid;
  spscq_pkg::status_e_t  s1_status;
  spscq_pkg::counts_t    s1_cnt;
  logic                  s1_adv;
  logic                  out_adv;
  logic [spscq_pkg::ELEM_W-1:0] store_rdata;

  logic                  m_valid;
  spscq_pkg::status_e_t  m_status;
  spscq_pkg::counts_t    m_cnt;
  logic [spscq_pkg::ELEM_W-1:0] m_rdata;

  function automatic spscq_pkg::counts_t calc_counts(
    input logic [SW-1:0] n,
    input logic [IW-1:0] h,
    input logic [IW-1:0] t
  );
    spscq_pkg::counts_t c;
    logic [SW-1:0] h9;
    logic [SW-1:0] t9;
    h9 = {1'b0, h};
    t9 = {1'b0, t};
    if (t <= h) begin
      c.contig_write = 8'(n - h9 - ((t == '0) ? SW'(1) : SW'(0)));
      c.avail_write  = 8'(n - h9 + t9 - SW'(1));
      c.contig_read  = 8'(h9 - t9);
      c.avail_read   = 8'(h9 - t9);
    end else begin
      c.contig_write = 8'(t9 - h9 - SW'(1));
      c.avail_write  = 8'(t9 - h9 - SW'(1));
      c.contig_read  = 8'(n - t9);
      c.avail_read   = 8'(n - t9 + h9);
    end
    return c;
  endfunction

  function automatic logic [IW-1:0] advance(
    input logic [SW-1:0] n,
    input logic [IW-1:0] pos,
    input logic [7:0]    by
  );
    logic [SW-1:0] p;
    p = {1'b0, pos} + {1'b0, by};
    if (p >= n) begin
      p = p - n;
    end
    return p[IW-1:0];
  endfunction

  assign cmd       = spscq_pkg::cmd_e_t'(s_axis_tuser);
  assign in_data   = s_axis_tdata[31:0];
  assign in_offset = s_axis_tdata[39:32];
  assign in_amount = s_axis_tdata[47:40];

  assign out_adv       = !m_valid || m_axis_tready;
  assign s1_adv        = s1_valid && out_adv;
  assign s_axis_tready = !s1_valid || out_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid && cfg_ready;

  assign wr_addr = {1'b0, head} + {1'b0, in_offset};
  assign rd_addr = {1'b0, tail} + {1'b0, in_offset};

  // size held to 2..DEPTH
  always_comb begin
    if (cfg_data < spscq_pkg::SIZE_MIN) begin
      cfg_size = spscq_pkg::SIZE_MIN;
    end else if (cfg_data > spscq_pkg::SIZE_MAX) begin
      cfg_size = spscq_pkg::SIZE_MAX;
    end else begin
      cfg_size = cfg_data;
    end
  end

  assign cnt_now = calc_counts(ring_n, head, tail);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    status_next = spscq_pkg::ST_OK;
    req.en      = in_fire;
    req.wr      = 1'b0;
    req.rd      = 1'b0;
    req.addr    = wr_addr[IW-1:0];
    req.wdata   = in_data;
    unique case (cmd)
      spscq_pkg::CMD_WRITE: begin
        // offset zero is the head slot, always writable
        if (in_offset < cnt_now.contig_write || in_offset == '0) begin
          req.wr = !wr_addr[SW-1];
        end else begin
          status_next = spscq_pkg::ST_RANGE;
        end
      end
      spscq_pkg::CMD_COMMIT: begin
        if (in_amount == '0) begin
          head_next = head;
        end else if (in_amount <= cnt_now.contig_write) begin
          head_next = advance(ring_n, head, in_amount);
        end else if (in_amount == 8'd1) begin
          status_next = spscq_pkg::ST_FULL;
        end else begin
          status_next = spscq_pkg::ST_RANGE;
        end
      end
      spscq_pkg::CMD_READ: begin
        req.addr = rd_addr[IW-1:0];
        if (head == tail) begin
          status_next = spscq_pkg::ST_EMPTY;
        end else if (in_offset < cnt_now.contig_read) begin
          req.rd = !rd_addr[SW-1];
        end else begin
          status_next = spscq_pkg::ST_RANGE;
        end
      end
      spscq_pkg::CMD_RELEASE: begin
        if (in_amount == '0) begin
          tail_next = tail;
        end else if (head == tail || in_amount > cnt_now.contig_read) begin
          status_next = spscq_pkg::ST_RANGE;
        end else begin
          tail_next = advance(ring_n, tail, in_amount);
        end
      end
      spscq_pkg::CMD_CLEAR: begin
        tail_next = head;
      end
      default: begin
        status_next = spscq_pkg::ST_RANGE;
      end
    endcase
  end

  assign cnt_next = calc_counts(ring_n, head_next, tail_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_n <= spscq_pkg::SIZE_MAX;
      head   <= '0;
      tail   <= '0;
    end else if (cfg_fire) begin
      ring_n <= cfg_size;
      head   <= '0;
      tail   <= '0;
    end else if (in_fire) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  spscq_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (store_rdata)
  );

  // stage one: status and counts wait here alongside the registered slot read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !out_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status <= status_next;
      s1_cnt    <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= s1_adv || (m_valid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_status <= s1_status;
      m_cnt    <= s1_cnt;
      m_rdata  <= store_rdata;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_cnt, m_rdata};
  assign m_axis_tuser  = m_status;

`ifndef NO_ASSERTIONS
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < ring_n)
    else $error("head index outside ring");

  a_tail_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tail} < ring_n)
    else $error("tail index outside ring");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ({1'b0, s1_cnt.avail_read} + {1'b0, s1_cnt.avail_write}
                  == ring_n - SW'(1)))
    else $error("free and queued counts do not add up to capacity");

  a_failed_read_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_status != spscq_pkg::ST_OK) |-> store_rdata == '0)
    else $error("read data not zero on failed command");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_adv) |=> (s1_valid && $stable(s1_cnt)))
    else $error("stage one result lost under stall");
`endif

endmodule
